FILE: rtl/rc5ke_pkg.sv
// Shared package for the RC5 key expansion block.
// Holds the magic constants, the controller command word type and the rotate helpers.
// No dependencies.
`timescale 1ns / 1ps

package rc5ke_pkg;

   localparam logic [31:0] MAGIC_P   = 32'hB7E15163;
   localparam logic [31:0] MAGIC_Q   = 32'h9E3779B9;
   localparam int          KEY_WORDS = 4;
   localparam int          ROT_FIXED = 3;

   typedef struct packed {
      logic load_key;
      logic fill;
      logic rd_table;
      logic mix_a;
      logic mix_b;
      logic rd_emit;
      logic load_out;
      logic last;
   } ctrl_cmd_type;

   function automatic logic [31:0] rotl_var(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] tmp;
      tmp = {v, v} << s;
      return tmp[63:32];
   endfunction

   function automatic logic [31:0] rotl_fixed(input logic [31:0] v);
      return {v[31-ROT_FIXED:0], v[31:32-ROT_FIXED]};
   endfunction

endpackage

FILE: rtl/rc5ke_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rc5ke_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 26
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rc5ke_ctrl.sv
// Sequencer for the RC5 key expansion: fill, mix and emit phases plus the result valid flag.
// Depends on rc5ke_pkg.
`timescale 1ns / 1ps

module rc5ke_ctrl
   import rc5ke_pkg::*;
#(
   parameter int SUBKEY_COUNT = 26
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ctrl_cmd_type                      cmd,
   output logic [$clog2(SUBKEY_COUNT)-1:0]   idx
);

   localparam int TW     = $clog2(SUBKEY_COUNT);
   localparam int ROUNDS = 3 * ((SUBKEY_COUNT > KEY_WORDS) ? SUBKEY_COUNT : KEY_WORDS);
   localparam int CW     = $clog2(ROUNDS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FILL  = 3'd1;
   localparam logic [2:0] ST_PRIME = 3'd2;
   localparam logic [2:0] ST_MIXA  = 3'd3;
   localparam logic [2:0] ST_MIXB  = 3'd4;
   localparam logic [2:0] ST_ERD   = 3'd5;
   localparam logic [2:0] ST_ELD   = 3'd6;

   localparam logic [CW-1:0] CNT_TABLE_LAST = CW'(SUBKEY_COUNT - 1);
   localparam logic [CW-1:0] CNT_MIX_LAST   = CW'(ROUNDS - 1);

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      cmd      = '0;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_key = 1'b1;
               cnt_in       = '0;
               state_in     = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (cnt_ff == CNT_TABLE_LAST) begin
               cnt_in   = '0;
               state_in = ST_PRIME;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PRIME: begin
            cmd.rd_table = 1'b1;
            state_in     = ST_MIXA;
         end
         ST_MIXA: begin
            cmd.mix_a = 1'b1;
            state_in  = ST_MIXB;
         end
         ST_MIXB: begin
            cmd.mix_b    = 1'b1;
            cmd.rd_table = 1'b1;
            if (cnt_ff == CNT_MIX_LAST) begin
               cnt_in   = '0;
               state_in = ST_ERD;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_MIXA;
            end
         end
         ST_ERD: begin
            cmd.rd_emit = 1'b1;
            state_in    = ST_ELD;
         end
         ST_ELD: begin
            if (!valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               cmd.last     = (cnt_ff == CNT_TABLE_LAST);
               valid_in     = 1'b1;
               if (cnt_ff == CNT_TABLE_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_ERD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;
   assign idx       = TW'(cnt_ff);

endmodule

FILE: rtl/rc5ke_dpath.sv
// Datapath for the RC5 key expansion: key words, mix registers, subkey table and result word.
// Depends on rc5ke_pkg and rc5ke_ram.
`timescale 1ns / 1ps

module rc5ke_dpath
   import rc5ke_pkg::*;
#(
   parameter int SUBKEY_COUNT = 26
) (
   input  logic                              clock,
   input  ctrl_cmd_type                      cmd,
   input  logic [$clog2(SUBKEY_COUNT)-1:0]   idx,
   input  logic [63:0]                       key_low,
   input  logic [63:0]                       key_high,
   output logic [4:0]                        subkey_index,
   output logic [31:0]                       subkey_word,
   output logic                              last_subkey
);

   localparam int TW = $clog2(SUBKEY_COUNT);
   localparam logic [TW-1:0] TI_LAST = TW'(SUBKEY_COUNT - 1);

   logic [31:0]   key_ff [KEY_WORDS];
   logic [31:0]   fill_ff;
   logic [31:0]   a_ff;
   logic [31:0]   b_ff;
   logic [TW-1:0] ti_ff;
   logic [1:0]    kj_ff;
   logic [4:0]    out_index_ff;
   logic [31:0]   out_word_ff;
   logic          out_last_ff;

   logic [31:0]   rd_data;
   logic [31:0]   a_next;
   logic [31:0]   sum_ab;
   logic [31:0]   b_next;
   logic [TW-1:0] ti_inc;
   logic [TW-1:0] ti_rd;
   logic          wr_en;
   logic [TW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          rd_en;
   logic [TW-1:0] rd_addr;

   assign a_next  = rotl_fixed(rd_data + a_ff + b_ff);
   assign sum_ab  = a_ff + b_ff;
   assign b_next  = rotl_var(key_ff[kj_ff] + sum_ab, sum_ab[4:0]);
   assign ti_inc  = (ti_ff == TI_LAST) ? '0 : ti_ff + 1'b1;
   assign ti_rd   = cmd.mix_b ? ti_inc : ti_ff;

   assign wr_en   = cmd.fill | cmd.mix_a;
   assign wr_addr = cmd.fill ? idx : ti_ff;
   assign wr_data = cmd.fill ? fill_ff : a_next;
   assign rd_en   = cmd.rd_table | cmd.rd_emit;
   assign rd_addr = cmd.rd_emit ? idx : ti_rd;

   rc5ke_ram #(
      .WIDTH (32),
      .DEPTH (SUBKEY_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff[0] <= key_low[31:0];
         key_ff[1] <= key_low[63:32];
         key_ff[2] <= key_high[31:0];
         key_ff[3] <= key_high[63:32];
         fill_ff   <= MAGIC_P;
         a_ff      <= '0;
         b_ff      <= '0;
         ti_ff     <= '0;
         kj_ff     <= '0;
      end
      if (cmd.fill) begin
         fill_ff <= fill_ff + MAGIC_Q;
      end
      if (cmd.mix_a) begin
         a_ff <= a_next;
      end
      if (cmd.mix_b) begin
         b_ff          <= b_next;
         key_ff[kj_ff] <= b_next;
         ti_ff         <= ti_inc;
         kj_ff         <= kj_ff + 1'b1;
      end
      if (cmd.load_out) begin
         out_index_ff <= 5'(idx);
         out_word_ff  <= rd_data;
         out_last_ff  <= cmd.last;
      end
   end

   assign subkey_index = out_index_ff;
   assign subkey_word  = out_word_ff;
   assign last_subkey  = out_last_ff;

endmodule

FILE: rtl/rc5_key_expansion.sv
// RC5-32 key schedule: expands a 128-bit key into SUBKEY_COUNT 32-bit subkeys.
// Top level joining rc5ke_ctrl and rc5ke_dpath; depends on rc5ke_pkg.
//
// Usage:
//   req_ channel carries one 128-bit key (req_key_low, req_key_high) per run.
//   rsp_ channel returns SUBKEY_COUNT words in table order, each with its
//   index; rsp_last_subkey marks the final word of the run.
//   One key is worked at a time; req_ready is high only between runs.
// Sequence (N = SUBKEY_COUNT, R = 3 * max(N, 4) mix iterations):
//   the table is filled with N words, then the first table read is primed,
//   then each of the R mix iterations adds/rotates into A, then into B; each
//   emitted word takes a table read, then an output register load. The pace
//   is set by the one-read, one-write table RAM and the two-step mix loop.
// Reset: synchronous, clears the sequencer and the result valid flag; the
//   table and key words hold no value until a key arrives.
// Stall: a low rsp_ready freezes the emit phase with the word held stable.
`timescale 1ns / 1ps

module rc5_key_expansion
   import rc5ke_pkg::*;
#(
   parameter int SUBKEY_COUNT = 26
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_key_low,
   input  logic [63:0] req_key_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_subkey_index,
   output logic [31:0] rsp_subkey_word,
   output logic        rsp_last_subkey
);

   localparam int TW = $clog2(SUBKEY_COUNT);

   ctrl_cmd_type  cmd;
   logic [TW-1:0] idx;

   rc5ke_ctrl #(
      .SUBKEY_COUNT (SUBKEY_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .idx       (idx)
   );

   rc5ke_dpath #(
      .SUBKEY_COUNT (SUBKEY_COUNT)
   ) u_dpath (
      .clock        (clock),
      .cmd          (cmd),
      .idx          (idx),
      .key_low      (req_key_low),
      .key_high     (req_key_high),
      .subkey_index (rsp_subkey_index),
      .subkey_word  (rsp_subkey_word),
      .last_subkey  (rsp_last_subkey)
   );

`ifndef SYNTHESIS
   a_no_key_during_mix: assert property (@(posedge clock) disable iff (reset)
      (cmd.mix_a || cmd.mix_b) |-> !req_ready)
      else $error("key port open during mix");

   a_mix_pairs: assert property (@(posedge clock) disable iff (reset)
      cmd.mix_a |=> cmd.mix_b)
      else $error("mix A step not followed by mix B step");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("result word overwritten before taken");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && cmd.last) |=> (req_ready && rsp_valid && rsp_last_subkey))
      else $error("run did not close after last word");
`endif

endmodule

FILE: tb/tb_rc5_key_expansion.sv
// Testbench for rc5_key_expansion: drives 128-bit keys, predicts the 26 subkeys of each
// schedule and checks every returned word in order, with random idling and back-pressure.
// Depends on rc5ke_pkg and rc5_key_expansion.
`timescale 1ns / 1ps

module tb_rc5_key_expansion
   import rc5ke_pkg::*;
();

   localparam int SUBKEYS    = 26;
   localparam int MIX_ROUNDS = 3 * SUBKEYS;

   typedef struct {
      logic [4:0]  index;
      logic [31:0] word;
      logic        last;
   } subkey_rec_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_key_low;
   logic [63:0] req_key_high;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [4:0]  rsp_subkey_index;
   logic [31:0] rsp_subkey_word;
   logic        rsp_last_subkey;

   subkey_rec_type pending_subkeys[$];
   subkey_rec_type want;
   int             failures;
   bit             tx_idle_on;
   bit             rx_idle_on;
   int             hold_request;
   int             hold_left;

   rc5_key_expansion #(.SUBKEY_COUNT(SUBKEYS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_low      (req_key_low),
      .req_key_high     (req_key_high),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_subkey_index (rsp_subkey_index),
      .rsp_subkey_word  (rsp_subkey_word),
      .rsp_last_subkey  (rsp_last_subkey)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] rotate_left(input logic [31:0] v, input logic [4:0] amount);
      if (amount == 5'd0)
         return v;
      return (v << amount) | (v >> (6'd32 - amount));
   endfunction

   // Run the full schedule for one key and queue its subkeys
   function automatic void expand_key(input logic [63:0] lo, input logic [63:0] hi);
      logic [31:0]    sched [SUBKEYS];
      logic [31:0]    kw [4];
      logic [31:0]    a;
      logic [31:0]    b;
      int             ti;
      int             kj;
      subkey_rec_type rec;
      kw[0] = lo[31:0];
      kw[1] = lo[63:32];
      kw[2] = hi[31:0];
      kw[3] = hi[63:32];
      sched[0] = MAGIC_P;
      for (int n = 1; n < SUBKEYS; n++)
         sched[n] = sched[n-1] + MAGIC_Q;
      a  = '0;
      b  = '0;
      ti = 0;
      kj = 0;
      for (int k = 0; k < MIX_ROUNDS; k++) begin
         a         = rotate_left(sched[ti] + a + b, 5'd3);
         sched[ti] = a;
         b         = rotate_left(kw[kj] + a + b, 5'(a + b));
         kw[kj]    = b;
         ti        = (ti + 1) % SUBKEYS;
         kj        = (kj + 1) % 4;
      end
      for (int n = 0; n < SUBKEYS; n++) begin
         rec.index = 5'(n);
         rec.word  = sched[n];
         rec.last  = (n == SUBKEYS - 1);
         pending_subkeys.push_back(rec);
      end
   endfunction

   task automatic send_key(input logic [63:0] lo, input logic [63:0] hi);
      int gap;
      gap = (tx_idle_on && $urandom_range(99) < 9) ? $urandom_range(1, 8) : 0;
      @(negedge clock);
      repeat (gap) @(negedge clock);
      req_valid    <= 1'b1;
      req_key_low  <= lo;
      req_key_high <= hi;
      do @(posedge clock); while (!req_ready);
      expand_key(lo, hi);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_subkeys.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [63:0] random_half();
      logic [63:0] v;
      case ($urandom_range(9))
         0:       v = 64'd1 << $urandom_range(63);
         1:       v = ~(64'd1 << $urandom_range(63));
         2:       v = {32'd0, 32'($urandom)};
         3:       v = {32'($urandom), 32'hFFFF_FFFF};
         default: v = {32'($urandom), 32'($urandom)};
      endcase
      return v;
   endfunction

   task automatic test_directed();
      send_key(64'd0, 64'd0);
      send_key('1, '1);
      send_key(64'd0, '1);
      send_key('1, 64'd0);
      send_key({16{4'hA}}, {16{4'h5}});
      send_key({16{4'h5}}, {16{4'hA}});
      send_key(64'd1, 64'd0);
      send_key(64'd0, 64'd1);
      send_key(64'h8000_0000_0000_0000, 64'd0);
      send_key(64'd0, 64'h8000_0000_0000_0000);
      send_key(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
      send_key(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
      send_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
      send_key(64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001);
      // repeat a key after others: each schedule must start afresh
      send_key(64'd0, 64'd0);
      send_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
   endtask

   task automatic test_random(input int count);
      logic [63:0] lo;
      logic [63:0] hi;
      for (int i = 0; i < count; i++) begin
         if (i > 0 && $urandom_range(19) == 0) begin
            send_key(lo, hi);
         end else begin
            lo = random_half();
            hi = random_half();
            send_key(lo, hi);
         end
      end
   endtask

   task automatic test_backpressure();
      hold_request = 700;
      test_random(4);
   endtask

   task automatic test_drain_pause();
      test_random(5);
      wait_drained();
      test_random(5);
   endtask

   task automatic test_no_idle();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      test_random(30);
      wait_drained();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // Receiver: random idling plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(rx_idle_on && $urandom_range(99) < 9);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_subkeys.size() == 0) begin
            $error("unexpected subkey word: index %0d, word %h", rsp_subkey_index,
                   rsp_subkey_word);
            failures++;
         end else begin
            want = pending_subkeys.pop_front();
            if (rsp_subkey_index !== want.index) begin
               $error("subkey_index: expected %0d, actual %0d", want.index, rsp_subkey_index);
               failures++;
            end
            if (rsp_subkey_word !== want.word) begin
               $error("subkey_word: expected %h, actual %h", want.word, rsp_subkey_word);
               failures++;
            end
            if (rsp_last_subkey !== want.last) begin
               $error("last_subkey: expected %0b, actual %0b", want.last, rsp_last_subkey);
               failures++;
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int waited;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_key_low  = '0;
      req_key_high = '0;
      rsp_ready    = 1'b0;
      failures     = 0;
      tx_idle_on   = 1'b1;
      rx_idle_on   = 1'b1;
      hold_request = 0;
      hold_left    = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_no_idle();
      test_random(180);
      test_backpressure();
      test_drain_pause();
      test_random(200);

      waited = 0;
      while (pending_subkeys.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (300) @(posedge clock);
      if (pending_subkeys.size() != 0) begin
         $error("%0d subkey words never arrived", pending_subkeys.size());
         failures++;
      end
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
